// ----- rtl/core/rese_pkg.sv -----
// ----------------------------------------------------------------------------
// rese_pkg
// Shared codes, constants, lookup tables and types for the reciprocal
// estimate / step unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rese_pkg;

  localparam logic [1:0] FN_RECIP_EST  = 2'd0;
  localparam logic [1:0] FN_RECIP_STEP = 2'd1;
  localparam logic [1:0] FN_RSQRT_EST  = 2'd2;
  localparam logic [1:0] FN_RSQRT_STEP = 2'd3;

  localparam logic [31:0] DEFAULT_NAN = 32'h7fc0_0000;
  localparam logic [30:0] INF_MAG     = 31'h7f80_0000;
  localparam logic [31:0] TWO_BITS    = 32'h4000_0000;
  localparam logic [31:0] HALF3_BITS  = 32'h3fc0_0000;  // 1.5
  localparam logic [7:0]  C_EXP       = 8'd128;
  localparam logic [23:0] C_MAN_TWO   = 24'h80_0000;
  localparam logic [23:0] C_MAN_THREE = 24'hc0_0000;

  // Product with a biased exponent offset in these bounds is handled as
  // overflow / as too small to move 2 - p or 3 - p.
  localparam logic [9:0] PEXP_OVF = 10'd382;
  localparam logic [9:0] PEXP_TINY = 10'd228;
  localparam logic [9:0] EXP_BIAS = 10'd127;

  // Request into the subtract pipeline
  typedef struct packed {
    logic        byp;
    logic [31:0] byp_val;
    logic        root;
    logic        p_sign;
    logic [7:0]  p_exp;
    logic [23:0] p_man;
  } rese_add_req_t;

  // Reciprocal table: entry i holds round(2^17 / (256 + i + 0.5)) - 256
  function automatic logic [2047:0] build_recip_lut();
    logic [2047:0] t;
    longint        q;
    longint        d;
    longint        s;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      q = 64'd256 + longint'(i);
      d = 2 * q + 1;
      s = 511;
      while (s > 256 && s * 2 * d > 524288 + d) s = s - 1;
      t[i*8 +: 8] = 8'(s - 256);
    end
    return t;
  endfunction

  // Root table: index {exp parity, top 7 mantissa bits}
  function automatic logic [2047:0] build_rsqrt_lut();
    logic [2047:0] t;
    longint        q;
    longint        d;
    longint        n4;
    longint        s;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      q  = 64'd128 + longint'(i % 128);
      d  = 2 * q + 1;
      n4 = (i >= 128) ? (64'd1 << 28) : (64'd1 << 27);
      s  = 511;
      while (s > 256 && (2 * s - 1) * (2 * s - 1) * d > n4) s = s - 1;
      t[i*8 +: 8] = 8'(s - 256);
    end
    return t;
  endfunction

  localparam logic [2047:0] RECIP_LUT = build_recip_lut();
  localparam logic [2047:0] RSQRT_LUT = build_rsqrt_lut();

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rese_fadd.sv -----
// ----------------------------------------------------------------------------
// rese_fadd
// Three-stage c - p subtract (c = 2 or 3), round to nearest even, optional
// halving for the root step. Bypass words ride along unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rese_fadd (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   req_valid,
  input  wire rese_pkg::rese_add_req_t req,
  output logic                        res_valid,
  output logic [31:0]                 res
);

  // ---- stage A: align and add ----
  logic [23:0] c_man;
  logic        y_sign;
  logic        y_big;
  logic [7:0]  big_exp, sm_exp, d;
  logic [23:0] big_man, sm_man;
  logic        big_sign, sm_sign;
  logic [26:0] sm_ext, sh;
  logic        st;
  logic [27:0] big_ext, al_ext, sum;

  always_comb begin
    c_man  = req.root ? rese_pkg::C_MAN_THREE : rese_pkg::C_MAN_TWO;
    y_sign = ~req.p_sign;
    y_big  = {req.p_exp, req.p_man} > {rese_pkg::C_EXP, c_man};
    if (y_big) begin
      big_exp = req.p_exp;     big_man = req.p_man; big_sign = y_sign;
      sm_exp  = rese_pkg::C_EXP; sm_man = c_man;    sm_sign  = 1'b0;
    end else begin
      big_exp = rese_pkg::C_EXP; big_man = c_man;   big_sign = 1'b0;
      sm_exp  = req.p_exp;     sm_man  = req.p_man; sm_sign  = y_sign;
    end
    d      = big_exp - sm_exp;
    sm_ext = {sm_man, 3'b000};
    if (d >= 8'd27) begin
      sh = '0;
      st = 1'b1;
    end else begin
      sh = sm_ext >> d;
      st = |(sm_ext & ~(27'h7ff_ffff << d));
    end
    big_ext = {1'b0, big_man, 3'b000};
    al_ext  = {1'b0, sh[26:1], sh[0] | st};
    sum     = (big_sign != sm_sign) ? (big_ext - al_ext) : (big_ext + al_ext);
  end

  logic        a_valid_r;
  logic [27:0] a_sum_r;
  logic [7:0]  a_exp_r;
  logic        a_sign_r, a_root_r, a_byp_r;
  logic [31:0] a_byp_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else a_valid_r <= req_valid;
    a_sum_r     <= sum;
    a_exp_r     <= big_exp;
    a_sign_r    <= big_sign;
    a_root_r    <= req.root;
    a_byp_r     <= req.byp;
    a_byp_val_r <= req.byp_val;
  end

  // ---- stage B: normalize ----
  logic [4:0]  lz;
  logic [26:0] nm_nxt;
  logic [8:0]  ne_nxt;

  always_comb begin
    lz = rese_pkg::lzc27(a_sum_r[26:0]);
    if (a_sum_r[27]) begin
      nm_nxt = {a_sum_r[27:2], a_sum_r[1] | a_sum_r[0]};
      ne_nxt = {1'b0, a_exp_r} + 9'd1;
    end else begin
      nm_nxt = a_sum_r[26:0] << lz;
      ne_nxt = {1'b0, a_exp_r} - {4'd0, lz};
    end
  end

  logic        b_valid_r;
  logic [26:0] b_man_r;
  logic [8:0]  b_exp_r;
  logic        b_zero_r, b_sign_r, b_root_r, b_byp_r;
  logic [31:0] b_byp_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else b_valid_r <= a_valid_r;
    b_man_r     <= nm_nxt;
    b_exp_r     <= ne_nxt;
    b_zero_r    <= (a_sum_r == 28'd0);
    b_sign_r    <= a_sign_r;
    b_root_r    <= a_root_r;
    b_byp_r     <= a_byp_r;
    b_byp_val_r <= a_byp_val_r;
  end

  // ---- stage C: round, halve, pack ----
  logic        up;
  logic [24:0] mr;
  logic [22:0] frac;
  logic [8:0]  ee;
  logic [31:0] res_nxt;

  always_comb begin
    up = b_man_r[2] & (b_man_r[1] | b_man_r[0] | b_man_r[3]);
    mr = {1'b0, b_man_r[26:3]} + {24'd0, up};
    if (mr[24]) begin
      frac = mr[23:1];
      ee   = b_exp_r + 9'd1;
    end else begin
      frac = mr[22:0];
      ee   = b_exp_r;
    end
    if (b_byp_r) res_nxt = b_byp_val_r;
    else if (b_zero_r) res_nxt = 32'd0;
    else if (ee >= 9'd255) res_nxt = {b_sign_r, rese_pkg::INF_MAG};
    else if (b_root_r) res_nxt = {b_sign_r, 8'(ee - 9'd1), frac};
    else res_nxt = {b_sign_r, ee[7:0], frac};
  end

  logic        c_valid_r;
  logic [31:0] c_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else c_valid_r <= b_valid_r;
    c_res_r <= res_nxt;
  end

  assign res_valid = c_valid_r;
  assign res       = c_res_r;

endmodule

`default_nettype wire

// ----- rtl/core/reciprocal_estimate_step_unit.sv -----
// ----------------------------------------------------------------------------
// reciprocal_estimate_step_unit
// Single-precision reciprocal / root estimates and Newton step terms.
//
//   channel  ports                              handshake
//   in       in_func, in_op_a, in_op_b          start & !busy
//   out      out_result                         out_valid strobe, one cycle
//
// Five register stages: operand decode + 24x24 multiply, product round,
// align/add, normalize, round/pack. One word enters every cycle.
// busy never rises: the pipeline has no stall and the receiver cannot stall.
// Synchronous reset clears only the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module reciprocal_estimate_step_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_op_a,
  input  wire logic [31:0] in_op_b,
  output logic             out_valid,
  output logic [31:0]      out_result
);

  assign busy = 1'b0;

  // ---- stage 1: decode, estimates, mantissa multiply ----
  logic [31:0] a, b;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [31:0] recip_val, rsqrt_val, est_val;
  logic [8:0]  rs_exp9;
  logic [7:0]  rc_idx, rs_idx;

  always_comb begin
    a = (in_op_a[30:23] == 8'd0) ? {in_op_a[31], 31'd0} : in_op_a;
    b = (in_op_b[30:23] == 8'd0) ? {in_op_b[31], 31'd0} : in_op_b;
    a_nan  = a[30:0] > rese_pkg::INF_MAG;
    b_nan  = b[30:0] > rese_pkg::INF_MAG;
    a_inf  = a[30:0] == rese_pkg::INF_MAG;
    b_inf  = b[30:0] == rese_pkg::INF_MAG;
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;

    rc_idx = a[22:15];
    rs_idx = {a[23], a[22:16]};
    if (a_nan) recip_val = rese_pkg::DEFAULT_NAN;
    else if (a[30:23] >= 8'd253) recip_val = {a[31], 31'd0};
    else if (a_zero) recip_val = {a[31], rese_pkg::INF_MAG};
    else recip_val = {a[31], 8'd253 - a[30:23], rese_pkg::RECIP_LUT[rc_idx*8 +: 8], 15'd0};

    rs_exp9 = 9'd380 - {1'b0, a[30:23]};
    if (a_nan) rsqrt_val = rese_pkg::DEFAULT_NAN;
    else if (a[31] && !a_zero) rsqrt_val = rese_pkg::DEFAULT_NAN;
    else if (a[30:23] >= 8'd253) rsqrt_val = 32'd0;
    else if (a_zero) rsqrt_val = {a[31], rese_pkg::INF_MAG};
    else rsqrt_val = {1'b0, rs_exp9[8:1], rese_pkg::RSQRT_LUT[rs_idx*8 +: 8], 15'd0};

    est_val = in_func[1] ? rsqrt_val : recip_val;
  end

  logic        s1_valid_r;
  logic [1:0]  s1_func_r;
  logic [31:0] s1_est_r;
  logic        s1_nan_r, s1_infzero_r, s1_inf_r, s1_zero_r, s1_sign_r;
  logic [8:0]  s1_esum_r;
  logic [47:0] s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= start & ~busy;
    s1_func_r    <= in_func;
    s1_est_r     <= est_val;
    s1_nan_r     <= a_nan | b_nan;
    s1_infzero_r <= (a_inf & b_zero) | (a_zero & b_inf);
    s1_inf_r     <= a_inf | b_inf;
    s1_zero_r    <= a_zero | b_zero;
    s1_sign_r    <= a[31] ^ b[31];
    s1_esum_r    <= {1'b0, a[30:23]} + {1'b0, b[30:23]};
    s1_prod_r    <= {1'b1, a[22:0]} * {1'b1, b[22:0]};
  end

  // ---- stage 2: round product, choose bypass word ----
  logic        norm, g, st, up, carry;
  logic [23:0] pman, pman_f;
  logic [24:0] pmr;
  logic [9:0]  pe_off;
  logic        root;
  rese_pkg::rese_add_req_t req_nxt;

  always_comb begin
    norm   = s1_prod_r[47];
    pman   = norm ? s1_prod_r[47:24] : s1_prod_r[46:23];
    g      = norm ? s1_prod_r[23] : s1_prod_r[22];
    st     = norm ? |s1_prod_r[22:0] : |s1_prod_r[21:0];
    up     = g & (st | pman[0]);
    pmr    = {1'b0, pman} + {24'd0, up};
    carry  = pmr[24];
    pman_f = carry ? pmr[24:1] : pmr[23:0];
    pe_off = {1'b0, s1_esum_r} + {9'd0, norm} + {9'd0, carry};
    root   = s1_func_r[1];

    req_nxt.root    = root;
    req_nxt.p_sign  = s1_sign_r;
    req_nxt.p_exp   = 8'(pe_off - rese_pkg::EXP_BIAS);
    req_nxt.p_man   = pman_f;
    req_nxt.byp     = 1'b1;
    if (!s1_func_r[0]) req_nxt.byp_val = s1_est_r;
    else if (s1_nan_r) req_nxt.byp_val = rese_pkg::DEFAULT_NAN;
    else if (s1_infzero_r || s1_zero_r || pe_off <= rese_pkg::PEXP_TINY)
      req_nxt.byp_val = root ? rese_pkg::HALF3_BITS : rese_pkg::TWO_BITS;
    else if (s1_inf_r || pe_off >= rese_pkg::PEXP_OVF)
      req_nxt.byp_val = {~s1_sign_r, rese_pkg::INF_MAG};
    else begin
      req_nxt.byp     = 1'b0;
      req_nxt.byp_val = rese_pkg::DEFAULT_NAN;
    end
  end

  logic                    s2_valid_r;
  rese_pkg::rese_add_req_t s2_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else s2_valid_r <= s1_valid_r;
    s2_req_r <= req_nxt;
  end

  rese_fadd u_fadd (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (s2_valid_r),
    .req       (s2_req_r),
    .res_valid (out_valid),
    .res       (out_result)
  );

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result without a word five cycles earlier");

  a_rc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_func == rese_pkg::FN_RECIP_EST &&
                       in_op_a[30:23] == 8'd0, 5)
    |-> out_result == {$past(in_op_a[31], 5), rese_pkg::INF_MAG})
    else $error("reciprocal estimate of zero is not infinity");

  a_rs_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_func == rese_pkg::FN_RSQRT_EST && !in_op_a[31], 5)
    |-> !out_result[31])
    else $error("root estimate of positive operand is negative");

  a_step_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && in_func == rese_pkg::FN_RECIP_STEP &&
                       in_op_a[30:0] > rese_pkg::INF_MAG, 5)
    |-> out_result == rese_pkg::DEFAULT_NAN)
    else $error("NaN operand to step did not give default NaN");
`endif

endmodule

`default_nettype wire
